/* src/tfci_pkg.sv */
// ----------------------------------------------------------------------------
// tfci_pkg
// Shared types and constants for the ATA task-file command issuer.
// ----------------------------------------------------------------------------
`default_nettype none

package tfci_pkg;

  // addressing_mode register codes
  localparam logic [1:0] MODE_CHS   = 2'd0;
  localparam logic [1:0] MODE_LBA28 = 2'd1;
  localparam logic [1:0] MODE_LBA48 = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_ADDR_MODE = 3'd0;
  localparam logic [2:0] CFG_DEVICE    = 3'd1;
  localparam logic [2:0] CFG_HEADS     = 3'd2;
  localparam logic [2:0] CFG_SPT       = 3'd3;
  localparam logic [2:0] CFG_IO_BASE   = 3'd4;

  // task-file register offsets
  localparam logic [2:0] OFS_NSECT   = 3'd2;
  localparam logic [2:0] OFS_LOW     = 3'd3;
  localparam logic [2:0] OFS_MID     = 3'd4;
  localparam logic [2:0] OFS_HIGH    = 3'd5;
  localparam logic [2:0] OFS_SELECT  = 3'd6;
  localparam logic [2:0] OFS_COMMAND = 3'd7;

  // command opcodes and select bits
  localparam logic [7:0] CMD_READ      = 8'h20;
  localparam logic [7:0] CMD_WRITE     = 8'h30;
  localparam logic [7:0] CMD_READ_EXT  = 8'h24;
  localparam logic [7:0] CMD_WRITE_EXT = 8'h34;
  localparam logic [7:0] SEL_LBA       = 8'h40;
  localparam logic [3:0] NIBBLE_MASK   = 4'hF;

  typedef enum logic [1:0] {
    K_CHS,
    K_LBA28,
    K_LBA48
  } kind_t;

  // one classified request, as it waits between front and back
  typedef struct packed {
    kind_t       kind;
    logic        func;
    logic [47:0] block;
    logic [15:0] count;
    logic [15:0] cyl;
    logic [3:0]  head;
    logic [7:0]  sect;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t data;
  } push_t;

  typedef struct packed {
    logic   empty;
    logic   full;
    entry_t head;
  } qstat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CYL,
    F_HEAD,
    F_PUSH
  } fstate_t;

  function automatic kind_t mode_to_kind(input logic [1:0] mode);
    kind_t k;
    unique case (mode)
      MODE_CHS:   k = K_CHS;
      MODE_LBA48: k = K_LBA48;
      default:    k = K_LBA28; // unused code acts as LBA28
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* src/tfci_front.sv */
// ----------------------------------------------------------------------------
// tfci_front
// Accepts requests and classifies them; CHS requests run through a shared
// bit-serial divider (cylinder, then head/sector) before they are queued.
// ----------------------------------------------------------------------------
`default_nettype none

module tfci_front
  import tfci_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [47:0] block,
  input  wire logic [15:0] sector_count,
  input  wire logic [1:0]  addressing_mode,
  input  wire logic [4:0]  head_count,
  input  wire logic [7:0]  sectors_per_track,
  input  wire qstat_t      qstat,
  output push_t            qpush
);

  fstate_t     state, state_next;
  logic [4:0]  cnt;
  logic [12:0] rem;
  logic [31:0] quo;
  logic [12:0] divisor;
  logic [7:0]  spt_hold;
  logic        func_hold;
  logic [15:0] count_hold;
  logic [15:0] cyl_hold;
  logic [3:0]  head_hold;
  logic [7:0]  sect_hold;

  logic        accept;
  kind_t       in_kind;
  logic [4:0]  heads_eff;
  logic [7:0]  spt_eff;
  logic [12:0] per_cyl;
  logic [13:0] trial;
  logic [14:0] diff;
  logic        ge;
  logic [12:0] rem_next;
  logic [31:0] quo_next;

  assign in_kind   = mode_to_kind(addressing_mode);
  assign heads_eff = (head_count == 5'd0) ? 5'd1 : head_count;
  assign spt_eff   = (sectors_per_track == 8'd0) ? 8'd1 : sectors_per_track;
  assign per_cyl   = 13'(heads_eff * spt_eff);
  assign accept    = in_valid && !in_stall;

  // one restoring-division step
  assign trial    = {rem, quo[31]};
  assign diff     = {1'b0, trial} - {2'b00, divisor};
  assign ge       = ~diff[14];
  assign rem_next = ge ? diff[12:0] : trial[12:0];
  assign quo_next = {quo[30:0], ge};

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept && in_kind == K_CHS) state_next = F_CYL;
      end
      F_CYL: begin
        if (cnt == 5'd0) state_next = F_HEAD;
      end
      F_HEAD: begin
        if (cnt == 5'd0) state_next = F_PUSH;
      end
      F_PUSH: begin
        if (!qstat.full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = (state != F_IDLE) || qstat.full;
    qpush.push      = 1'b0;
    qpush.data      = '0;
    unique case (state)
      F_IDLE: begin
        qpush.push       = accept && (in_kind != K_CHS);
        qpush.data.kind  = in_kind;
        qpush.data.func  = func;
        qpush.data.block = block;
        qpush.data.count = sector_count;
      end
      F_PUSH: begin
        qpush.push       = !qstat.full;
        qpush.data.kind  = K_CHS;
        qpush.data.func  = func_hold;
        qpush.data.count = count_hold;
        qpush.data.cyl   = cyl_hold;
        qpush.data.head  = head_hold;
        qpush.data.sect  = sect_hold;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          func_hold  <= func;
          count_hold <= sector_count;
          spt_hold   <= spt_eff;
          divisor    <= per_cyl;
          quo        <= block[31:0];
          rem        <= '0;
          cnt        <= 5'd31;
        end
      end
      F_CYL: begin
        if (cnt == 5'd0) begin
          // cylinder done; divide the remainder by sectors per track
          cyl_hold <= quo_next[15:0];
          quo      <= {rem_next, 19'd0};
          rem      <= '0;
          divisor  <= {5'd0, spt_hold};
          cnt      <= 5'd12;
        end else begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt - 5'd1;
        end
      end
      F_HEAD: begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          head_hold <= quo_next[3:0];
          sect_hold <= rem_next[7:0] + 8'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* src/tfci_queue.sv */
// ----------------------------------------------------------------------------
// tfci_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module tfci_queue
  import tfci_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t qpush,
  input  wire logic  pop,
  output qstat_t     qstat
);

  entry_t     mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign qstat.empty = (fill == 2'd0);
  assign qstat.full  = (fill == 2'd2);
  assign qstat.head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (qpush.push) mem[wr_ptr] <= qpush.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (qpush.push) wr_ptr <= ~wr_ptr;
      if (pop)        rd_ptr <= ~rd_ptr;
      unique case ({qpush.push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/tfci_back.sv */
// ----------------------------------------------------------------------------
// tfci_back
// Steps through the queued request, one task-file write per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfci_back
  import tfci_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire qstat_t      qstat,
  output logic             pop,
  input  wire logic        device_number,
  input  wire logic [15:0] io_base,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      port_address,
  output logic [7:0]       write_byte,
  output logic             last
);

  logic [3:0] step;
  logic       advance;
  logic       last_step;
  logic [2:0] ofs;
  logic [7:0] wbyte;
  entry_t     e;
  logic [7:0] dev;
  logic [7:0] opc;

  assign e   = qstat.head;
  assign dev = {3'b000, device_number, 4'h0};

  always_comb begin
    if (e.kind == K_LBA48) opc = e.func ? CMD_WRITE_EXT : CMD_READ_EXT;
    else                   opc = e.func ? CMD_WRITE : CMD_READ;
  end

  assign last_step = (e.kind == K_LBA48) ? (step == 4'd9) : (step == 4'd5);
  assign advance   = !qstat.empty && (!out_valid || !out_stall);
  assign pop       = advance && last_step;

  // write sequence per addressing kind
  always_comb begin
    ofs   = OFS_COMMAND;
    wbyte = opc;
    unique case (e.kind)
      K_LBA48: begin
        unique case (step)
          4'd0:    begin ofs = OFS_LOW;    wbyte = e.block[31:24]; end
          4'd1:    begin ofs = OFS_MID;    wbyte = e.block[39:32]; end
          4'd2:    begin ofs = OFS_HIGH;   wbyte = e.block[47:40]; end
          4'd3:    begin ofs = OFS_LOW;    wbyte = e.block[7:0];   end
          4'd4:    begin ofs = OFS_MID;    wbyte = e.block[15:8];  end
          4'd5:    begin ofs = OFS_HIGH;   wbyte = e.block[23:16]; end
          4'd6:    begin ofs = OFS_SELECT; wbyte = SEL_LBA | dev;  end
          4'd7:    begin ofs = OFS_NSECT;  wbyte = e.count[15:8];  end
          4'd8:    begin ofs = OFS_NSECT;  wbyte = e.count[7:0];   end
          default: begin ofs = OFS_COMMAND; wbyte = opc;           end
        endcase
      end
      K_CHS: begin
        unique case (step)
          4'd0:    begin ofs = OFS_MID;    wbyte = e.cyl[7:0];  end
          4'd1:    begin ofs = OFS_HIGH;   wbyte = e.cyl[15:8]; end
          4'd2:    begin ofs = OFS_SELECT; wbyte = dev | {4'h0, e.head & NIBBLE_MASK}; end
          4'd3:    begin ofs = OFS_LOW;    wbyte = e.sect;      end
          4'd4:    begin ofs = OFS_NSECT;  wbyte = e.count[7:0]; end
          default: begin ofs = OFS_COMMAND; wbyte = opc;        end
        endcase
      end
      default: begin
        unique case (step)
          4'd0:    begin ofs = OFS_LOW;  wbyte = e.block[7:0];   end
          4'd1:    begin ofs = OFS_MID;  wbyte = e.block[15:8];  end
          4'd2:    begin ofs = OFS_HIGH; wbyte = e.block[23:16]; end
          4'd3:    begin
            ofs   = OFS_SELECT;
            wbyte = SEL_LBA | dev | {4'h0, e.block[27:24] & NIBBLE_MASK};
          end
          4'd4:    begin ofs = OFS_NSECT; wbyte = e.count[7:0]; end
          default: begin ofs = OFS_COMMAND; wbyte = opc;        end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        step      <= last_step ? 4'd0 : step + 4'd1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      port_address <= io_base + {13'd0, ofs};
      write_byte   <= wbyte;
      last         <= last_step;
    end
  end

endmodule

`default_nettype wire

/* src/ata_taskfile_command_issuer.sv */
// ----------------------------------------------------------------------------
// Flow: an LBA request is written into the queue on its accept edge; its first
//   write then leaves through the registered output stage. A CHS request first
//   runs the serial divider (32 cylinder, 13 head/sector bits) before the push.
// Throughput: one write per cycle from the back part while out_stall is low;
//   LBA28 and CHS requests take six writes, an LBA48 request ten. The front
//   accepts nothing while the single bit-serial divider splits a CHS request.
// Reset: configuration returns to its defaults, queue and output empty.
// ----------------------------------------------------------------------------
// ata_taskfile_command_issuer
// Turns read/write sector requests into ordered ATA task-file byte writes.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_taskfile_command_issuer
  import tfci_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        func,
  input  wire logic [47:0] block,
  input  wire logic [15:0] sector_count,
  // write channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      port_address,
  output logic [7:0]       write_byte,
  output logic             last
);

  // configuration registers; the user must write only while idle, not checked
  logic [1:0]  addressing_mode;
  logic        device_number;
  logic [4:0]  head_count;
  logic [7:0]  sectors_per_track;
  logic [15:0] io_base;

  push_t  qpush;
  qstat_t qstat;
  logic   pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      addressing_mode   <= MODE_LBA28;
      device_number     <= 1'b0;
      head_count        <= 5'd16;
      sectors_per_track <= 8'd63;
      io_base           <= 16'd496;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADDR_MODE: addressing_mode   <= cfg_data[1:0];
        CFG_DEVICE:    device_number     <= cfg_data[0];
        CFG_HEADS:     head_count        <= cfg_data[4:0];
        CFG_SPT:       sectors_per_track <= cfg_data[7:0];
        CFG_IO_BASE:   io_base           <= cfg_data;
        default: ; // indexes past the register list are ignored
      endcase
    end
  end

  // front: accept, classify, CHS geometry split
  tfci_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .func              (func),
    .block             (block),
    .sector_count      (sector_count),
    .addressing_mode   (addressing_mode),
    .head_count        (head_count),
    .sectors_per_track (sectors_per_track),
    .qstat             (qstat),
    .qpush             (qpush)
  );

  // decoupling queue: lets the front take the next request while the back
  // is still issuing the previous one
  tfci_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .qpush (qpush),
    .pop   (pop),
    .qstat (qstat)
  );

  // back: write sequencer with registered output
  tfci_back u_back (
    .clk           (clk),
    .rst           (rst),
    .qstat         (qstat),
    .pop           (pop),
    .device_number (device_number),
    .io_base       (io_base),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .port_address  (port_address),
    .write_byte    (write_byte),
    .last          (last)
  );

endmodule

`default_nettype wire

/* src/tfci_checker.sv */
// ----------------------------------------------------------------------------
// tfci_port_checks
// Port-level checks on the write channel of the command issuer.
// ----------------------------------------------------------------------------
`default_nettype none

module tfci_port_checks
  import tfci_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] port_address,
  input wire logic [7:0]  write_byte,
  input wire logic        last
);

  // output stage comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("write valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled write dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(port_address) && $stable(write_byte) && $stable(last))
    else $error("stalled write changed");

  // the closing write always carries a command opcode
  a_last_opcode: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> write_byte == CMD_READ || write_byte == CMD_WRITE ||
                          write_byte == CMD_READ_EXT || write_byte == CMD_WRITE_EXT)
    else $error("last write is not a command");

endmodule

bind ata_taskfile_command_issuer tfci_port_checks u_tfci_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .port_address (port_address),
  .write_byte   (write_byte),
  .last         (last)
);

`default_nettype wire
